// ----- design/utf8s_pkg.sv -----
// ============================================================================
// utf8s_pkg
// Shared types and constants of the UTF-8 sanitizer.
// ============================================================================
`default_nettype none

package utf8s_pkg;

    localparam int unsigned MAX_RESULTS = 12;
    localparam int unsigned CNT_W       = 4;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [20:0] SURR_LO  = 21'h00D800;
    localparam logic [20:0] SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] CODE_MAX = 21'h10FFFF;
    localparam logic [20:0] MIN_2B   = 21'h000080;
    localparam logic [20:0] MIN_3B   = 21'h000800;
    localparam logic [20:0] MIN_4B   = 21'h010000;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1B   = 3'd1;
    localparam logic [2:0] LEN_2B   = 3'd2;
    localparam logic [2:0] LEN_3B   = 3'd3;
    localparam logic [2:0] LEN_4B   = 3'd4;

    typedef struct packed {
        logic [7:0]      lead;
        logic [2:0][7:0] cont;
        logic [2:0]      seq_len;
        logic [1:0]      held;
    } seq_state_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
    } result_t;

endpackage

`default_nettype wire

// ----- design/utf8_sanitizer_with_replacement_top.sv -----
// ============================================================================
// utf8_sanitizer_with_replacement_top
// The first output byte is presented in the cycle after the input transaction.
// Throughput: one input byte per cycle while each byte yields at most one
// output byte and m_tready holds; a byte yielding more than one output holds the
// input until its results have left the result buffer.
// Reset: synchronous active-low aresetn clears sequence state and empties the buffer.
// ============================================================================
`default_nettype none

module utf8_sanitizer_with_replacement_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // run_last
    output logic            m_tuser    // [0] stream_last
);

    utf8s_pkg::seq_state_t st_reg;
    utf8s_pkg::seq_state_t st_next;
    utf8s_pkg::result_t    res;

    logic [utf8s_pkg::MAX_RESULTS-1:0][7:0] data_reg;
    logic [utf8s_pkg::CNT_W-1:0]            rem_reg;
    logic [utf8s_pkg::CNT_W-1:0]            idx_reg;
    logic                                   last_reg;

    logic s_xfer;
    logic m_xfer;

    utf8s_step u_step (
        .st      (st_reg),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .st_next (st_next),
        .res     (res)
    );

    assign m_tvalid = (rem_reg != '0);
    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = (rem_reg == '0) || (rem_reg == 4'd1 && m_tready);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tdata  = data_reg[idx_reg];
    assign m_tlast  = (rem_reg == 4'd1);
    assign m_tuser  = (rem_reg == 4'd1) && last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            rem_reg <= '0;
            idx_reg <= '0;
        end else begin
            if (s_xfer) begin
                st_reg  <= st_next;
                rem_reg <= res.count;
                idx_reg <= '0;
            end else if (m_xfer) begin
                rem_reg <= rem_reg - 4'd1;
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            data_reg <= res.bytes;
            last_reg <= s_tlast;
        end
    end

`ifndef SYNTH
    a_last_gives_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tlast) |=> (m_tvalid && rem_reg <= 4'd12))
        else $error("stream end produced no output");

    a_last_closes_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tlast) |=> (st_reg.seq_len == utf8s_pkg::LEN_NONE))
        else $error("sequence left open after stream end");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg > 4'd1) |-> !s_tready)
        else $error("input accepted while results pending");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && !s_xfer) |=> (({1'b0, idx_reg} + {1'b0, rem_reg})
            == ({1'b0, $past(idx_reg)} + {1'b0, $past(rem_reg)})))
        else $error("result buffer pointer drift");
`endif

endmodule

`default_nettype wire

// ----- design/utf8s_step.sv -----
// ============================================================================
// utf8s_step
// Per-byte decode: next sequence state and the output bytes for one input.
// ============================================================================
`default_nettype none

module utf8s_step (
    input  wire utf8s_pkg::seq_state_t st,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    output utf8s_pkg::seq_state_t      st_next,
    output utf8s_pkg::result_t         res
);

    localparam logic [2:0][7:0] REPL = {utf8s_pkg::REPL_B2, utf8s_pkg::REPL_B1,
                                        utf8s_pkg::REPL_B0};

    function automatic logic [2:0] lead_class(input logic [7:0] c);
        logic [2:0] n;
        if (c < 8'h80) begin
            n = utf8s_pkg::LEN_1B;
        end else if (c >= 8'hC2 && c <= 8'hDF) begin
            n = utf8s_pkg::LEN_2B;
        end else if (c >= 8'hE0 && c <= 8'hEF) begin
            n = utf8s_pkg::LEN_3B;
        end else if (c >= 8'hF0 && c <= 8'hF4) begin
            n = utf8s_pkg::LEN_4B;
        end else begin
            n = utf8s_pkg::LEN_NONE;
        end
        return n;
    endfunction

    logic            is_open;
    logic            is_cont;
    logic [2:0]      cls;
    logic [2:0]      held_new;
    logic [2:0][7:0] cont_new;
    logic            complete;
    logic [20:0]     cp;
    logic            seq_ok;
    logic            scan;
    logic [2:0]      r1;
    logic [3:0][7:0] tail;
    logic [2:0]      tail_len;
    logic [3:0]      rep_len;
    logic [3:0]      off;

    assign is_open  = (st.seq_len >= utf8s_pkg::LEN_2B) && (st.seq_len <= utf8s_pkg::LEN_4B);
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign cls      = lead_class(in_byte);
    assign held_new = {1'b0, st.held} + 3'd1;
    assign complete = (held_new + 3'd1) >= st.seq_len;

    always_comb begin
        cont_new = st.cont;
        if (st.held != 2'd3) begin
            cont_new[st.held] = in_byte;
        end
    end

    always_comb begin
        case (st.seq_len)
            utf8s_pkg::LEN_2B: cp = {10'd0, st.lead[4:0], cont_new[0][5:0]};
            utf8s_pkg::LEN_3B: cp = {5'd0, st.lead[3:0], cont_new[0][5:0], cont_new[1][5:0]};
            default:           cp = {st.lead[2:0], cont_new[0][5:0], cont_new[1][5:0],
                                     cont_new[2][5:0]};
        endcase
        seq_ok = !(cp >= utf8s_pkg::SURR_LO && cp <= utf8s_pkg::SURR_HI)
                 && (cp <= utf8s_pkg::CODE_MAX)
                 && !(st.seq_len == utf8s_pkg::LEN_2B && cp < utf8s_pkg::MIN_2B)
                 && !(st.seq_len == utf8s_pkg::LEN_3B && cp < utf8s_pkg::MIN_3B)
                 && !(st.seq_len == utf8s_pkg::LEN_4B && cp < utf8s_pkg::MIN_4B);
    end

    always_comb begin
        st_next  = st;
        scan     = 1'b0;
        r1       = 3'd0;
        tail     = '0;
        tail_len = 3'd0;
        if (!is_open) begin
            st_next.seq_len = utf8s_pkg::LEN_NONE;
            st_next.held    = 2'd0;
            scan            = 1'b1;
        end else if (is_cont) begin
            st_next.cont = cont_new;
            st_next.held = held_new[1:0];
            if (complete) begin
                st_next.seq_len = utf8s_pkg::LEN_NONE;
                st_next.held    = 2'd0;
                if (seq_ok) begin
                    tail     = {cont_new[2], cont_new[1], cont_new[0], st.lead};
                    tail_len = st.seq_len;
                end else begin
                    r1 = st.seq_len;
                end
            end else if (in_last) begin
                st_next.seq_len = utf8s_pkg::LEN_NONE;
                st_next.held    = 2'd0;
                r1              = held_new + 3'd1;
            end
        end else begin
            st_next.seq_len = utf8s_pkg::LEN_NONE;
            st_next.held    = 2'd0;
            r1              = {1'b0, st.held} + 3'd1;
            scan            = 1'b1;
        end

        if (scan) begin
            case (cls)
                utf8s_pkg::LEN_1B: begin
                    tail[0]  = in_byte;
                    tail_len = 3'd1;
                end
                utf8s_pkg::LEN_NONE: begin
                    tail     = {8'h00, REPL[2], REPL[1], REPL[0]};
                    tail_len = 3'd3;
                end
                default: begin
                    if (in_last) begin
                        tail     = {8'h00, REPL[2], REPL[1], REPL[0]};
                        tail_len = 3'd3;
                    end else begin
                        st_next.lead    = in_byte;
                        st_next.seq_len = cls;
                        st_next.held    = 2'd0;
                    end
                end
            endcase
        end
    end

    assign rep_len   = {r1, 1'b0} + {1'b0, r1};
    assign res.count = rep_len + {1'b0, tail_len};

    always_comb begin
        off = 4'd0;
        for (int i = 0; i < int'(utf8s_pkg::MAX_RESULTS); i++) begin
            off = 4'(i) - rep_len;
            if (4'(i) < rep_len) begin
                res.bytes[i] = REPL[i % 3];
            end else if (off < 4'd4) begin
                res.bytes[i] = tail[off[1:0]];
            end else begin
                res.bytes[i] = 8'h00;
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_utf8_sanitizer_with_replacement_top.sv -----
// ============================================================================
// tb_utf8_sanitizer_with_replacement_top
// Streams raw bytes into the UTF-8 sanitizer with random bursts and output
// backpressure. A scoreboard keeps its own decoder state, predicts the
// sanitized bytes with their run and stream end flags, and checks every
// output transaction in order.
// ============================================================================

module tb_utf8_sanitizer_with_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    class utf8_repl_board;
        typedef struct {
            logic [7:0] data;
            logic       run_end;
            logic       stream_end;
        } out_item_t;

        logic [7:0]  lead;
        logic [7:0]  cont [3];
        logic [2:0]  seq_len;
        logic [1:0]  held;
        logic [7:0]  step_out [$];
        out_item_t   pending_out [$];
        int unsigned n_in;
        int unsigned n_streams;
        int unsigned n_out;
        int unsigned n_repl;
        int unsigned n_err;

        function new();
            lead = '0;
            foreach (cont[k]) cont[k] = '0;
            seq_len = utf8s_pkg::LEN_NONE;
            held = '0;
            n_in = 0;
            n_streams = 0;
            n_out = 0;
            n_repl = 0;
            n_err = 0;
        endfunction

        function void put_byte(logic [7:0] c);
            step_out.insert(step_out.size(), c);
        endfunction

        function void put_repl();
            put_byte(utf8s_pkg::REPL_B0);
            put_byte(utf8s_pkg::REPL_B1);
            put_byte(utf8s_pkg::REPL_B2);
            n_repl++;
        endfunction

        // one U+FFFD for the lead and one per held continuation byte
        function void replace_open();
            put_repl();
            for (int k = 0; k < held; k++) put_repl();
            seq_len = utf8s_pkg::LEN_NONE;
            held = '0;
        endfunction

        function logic [2:0] lead_len(logic [7:0] c);
            if (c < 8'h80) return utf8s_pkg::LEN_1B;
            if (c >= 8'hC2 && c <= 8'hDF) return utf8s_pkg::LEN_2B;
            if (c >= 8'hE0 && c <= 8'hEF) return utf8s_pkg::LEN_3B;
            if (c >= 8'hF0 && c <= 8'hF4) return utf8s_pkg::LEN_4B;
            return utf8s_pkg::LEN_NONE;
        endfunction

        function void scan_lead(logic [7:0] c);
            logic [2:0] n;
            n = lead_len(c);
            if (n == utf8s_pkg::LEN_1B) begin
                put_byte(c);
            end else if (n == utf8s_pkg::LEN_NONE) begin
                put_repl();
            end else begin
                lead = c;
                seq_len = n;
                held = '0;
            end
        endfunction

        function void close_complete();
            logic [20:0] cp;
            logic        ok;
            case (seq_len)
                utf8s_pkg::LEN_2B: cp = {16'd0, lead[4:0]};
                utf8s_pkg::LEN_3B: cp = {17'd0, lead[3:0]};
                default:           cp = {18'd0, lead[2:0]};
            endcase
            for (int k = 0; k + 1 < seq_len; k++) cp = {cp[14:0], cont[k][5:0]};
            ok = !(cp >= utf8s_pkg::SURR_LO && cp <= utf8s_pkg::SURR_HI)
                 && cp <= utf8s_pkg::CODE_MAX
                 && !(seq_len == utf8s_pkg::LEN_2B && cp < utf8s_pkg::MIN_2B)
                 && !(seq_len == utf8s_pkg::LEN_3B && cp < utf8s_pkg::MIN_3B)
                 && !(seq_len == utf8s_pkg::LEN_4B && cp < utf8s_pkg::MIN_4B);
            if (ok) begin
                put_byte(lead);
                for (int k = 0; k + 1 < seq_len; k++) put_byte(cont[k]);
                seq_len = utf8s_pkg::LEN_NONE;
                held = '0;
            end else begin
                replace_open();
            end
        endfunction

        function void take_byte(logic [7:0] c, logic last);
            out_item_t item;
            n_in++;
            if (last) n_streams++;
            step_out.delete();
            if (seq_len < utf8s_pkg::LEN_2B || seq_len > utf8s_pkg::LEN_4B) begin
                seq_len = utf8s_pkg::LEN_NONE;
                held = '0;
                scan_lead(c);
            end else if (c[7:6] == 2'b10) begin
                cont[held] = c;
                held = held + 2'd1;
                if (3'(held) + 3'd1 >= seq_len) close_complete();
            end else begin
                replace_open();
                scan_lead(c);
            end
            if (last && seq_len != utf8s_pkg::LEN_NONE) replace_open();
            foreach (step_out[k]) begin
                item.data = step_out[k];
                item.run_end = (k == step_out.size() - 1);
                item.stream_end = item.run_end && last;
                pending_out.insert(pending_out.size(), item);
            end
        endfunction

        function void check_out_byte(logic [7:0] d, logic rl, logic sl);
            out_item_t want;
            n_out++;
            if (pending_out.size() == 0) begin
                $error("unexpected output transaction: out_byte %02h", d);
                n_err++;
                return;
            end
            want = pending_out.pop_front();
            if (d !== want.data) begin
                $error("out_byte: expected %02h, got %02h", want.data, d);
                n_err++;
            end
            if (rl !== want.run_end) begin
                $error("run_last: expected %0b, got %0b", want.run_end, rl);
                n_err++;
            end
            if (sl !== want.stream_end) begin
                $error("stream_last: expected %0b, got %0b", want.stream_end, sl);
                n_err++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic       s_tlast = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;           // run_last
    logic       m_tuser;           // [0] stream_last

    utf8_repl_board board;
    int         burst_left = 0;
    int         n_sent = 0;
    logic [7:0] rx_tick = 8'd0;

    // {in_last, in_byte}
    logic [8:0] opening_seq [0:23] = '{
        9'h000, 9'h0FF, 9'h080, 9'h0C1, 9'h0F5, 9'h17F,
        9'h0C2, 9'h080,                    // smallest two-byte code point
        9'h0ED, 9'h0A0, 9'h080,            // surrogate
        9'h0F4, 9'h090, 9'h080, 9'h080,    // above 10FFFF
        9'h0E0, 9'h09F, 9'h0BF,            // overlong three-byte
        9'h0E2, 9'h082, 9'h041,            // broken after one held byte
        9'h0F0, 9'h090, 9'h180             // flushed at end of stream
    };

    utf8_sanitizer_with_replacement_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // input transactions are noted before output checks at the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_out_byte(m_tdata, m_tlast, m_tuser);
        end
        rx_tick <= rx_tick + 8'd1;
        case (rx_tick[7:6])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= rx_tick[2];
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 60);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (board.pending_out.size() != 0);
        @(posedge aclk);
        burst_left = $urandom_range(1, 60);
    endtask

    // mostly lead plus continuation bytes with random payload, some truncated
    task automatic send_random_group();
        logic [7:0] grp [$];
        logic [7:0] b;
        int         pick;
        int         n;
        int         ncont;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            grp.insert(grp.size(), 8'($urandom_range(0, 127)));
        end else if (pick < 25) begin
            grp.insert(grp.size(), 8'($urandom));
        end else begin
            if (pick < 85) begin
                n = $urandom_range(2, 4);
                case (n)
                    2:       b = 8'($urandom_range(8'hC2, 8'hDF));
                    3:       b = 8'($urandom_range(8'hE0, 8'hEF));
                    default: b = 8'($urandom_range(8'hF0, 8'hF4));
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0:       b = 8'hE0;
                    1:       b = 8'hED;
                    2:       b = 8'hF0;
                    default: b = 8'hF4;
                endcase
                n = (b[4]) ? 4 : 3;
            end
            grp.insert(grp.size(), b);
            ncont = n - 1;
            if ($urandom_range(0, 4) == 0) ncont = $urandom_range(0, n - 2);
            repeat (ncont) grp.insert(grp.size(), 8'h80 | 8'($urandom_range(0, 63)));
            if (ncont < n - 1) begin
                b = 8'($urandom);
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                grp.insert(grp.size(), b);
            end
        end
        foreach (grp[k]) send_byte(grp[k], $urandom_range(0, 24) == 0);
    endtask

    initial begin
        logic drained_mid;
        drained_mid = 1'b0;
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (opening_seq[k]) send_byte(opening_seq[k][7:0], opening_seq[k][8]);
        wait_drained();
        while (n_sent < 450) begin
            if (!drained_mid && n_sent > 250) begin
                wait_drained();
                drained_mid = 1'b1;
            end
            send_random_group();
        end
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Run: %0d input bytes in %0d terminated streams, %0d output bytes checked",
                 board.n_in, board.n_streams, board.n_out);
        $display("     %0d replacement characters predicted, %0d mismatches",
                 board.n_repl, board.n_err);
        if (board.n_err == 0) begin
            $display("tb_utf8_sanitizer_with_replacement_top passed");
        end else begin
            $display("tb_utf8_sanitizer_with_replacement_top failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timeout waiting for the sanitizer");
        $display("tb_utf8_sanitizer_with_replacement_top failed");
        $finish;
    end

endmodule
